// ===== design/bmhq_pkg.sv =====
// bmhq_pkg: shared types and codes for the binary min-heap queue
// no dependencies
`timescale 1ns / 1ps
package bmhq_pkg;
  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // packed from the top down: tag, rank, distance in the lowest bits
  typedef struct packed {
    logic [9:0]  tag;
    logic [7:0]  rnk;
    logic [15:0] distance;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD0, S_DN_RD1, S_DN_RD2, S_DN_CMP,
    S_TOP_RD, S_TOP_WT, S_OUT
  } state_t;

  // strict ordering: a is served before b
  function automatic logic goes_before(entry_t a, entry_t b);
    if (a.distance != b.distance) return a.distance < b.distance;
    return a.rnk < b.rnk;
  endfunction
endpackage

// ===== design/binary_min_heap_queue_core.sv =====
// binary_min_heap_queue_core: top level of the min-heap priority queue
// depends on bmhq_pkg
`timescale 1ns / 1ps
// Usage:
//  in_* stream carries one command per transfer: enqueue, dequeue, peek or no-op.
//  out_* stream returns one result per command: status, root entry after the
//  operation, entry count, empty and full flags.
//  Entries live in one memory (one read, one write per cycle, registered read
//  data). A sequencer walks the heap one level per step: sift up reads the
//  parent, then compares and writes per level; sift down first fetches the last
//  entry, then per level reads the left child, reads the right child, and
//  compares and writes; then the root is read and the result registered.
//  One command is worked at a time; in_tready is high only while idle.
//  The result stays in an output register until taken; a stalled receiver holds
//  the block in its output state and no new command is accepted.
//  Reset clears the fill count and the sequencer; memory content is not cleared,
//  no clearing pass is needed since only entries below the count are used.
module binary_min_heap_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: command[1:0], distance[17:2], rank[25:18], payload_tag[35:26]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: status[1:0], top_distance[17:2], top_rank[25:18], top_tag[35:26],
  // entry_count[42:36], is_empty[43], is_full[44]
  output logic [47:0] out_tdata
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // heap memory
  bmhq_pkg::entry_t mem [CAPACITY];
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  bmhq_pkg::entry_t wr_data, rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  bmhq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW:0] pos_r, pos_nxt, best_r, best_nxt;
  bmhq_pkg::entry_t cur_r, cur_nxt, bent_r, bent_nxt;
  logic [1:0] st_r, st_nxt;
  logic [47:0] odata_r, odata_nxt;

  logic [AW:0] par, lch, rch;
  assign par = (pos_r - 1'b1) >> 1;
  assign lch = {pos_r[AW-1:0], 1'b1};
  assign rch = lch + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r <= pos_nxt; best_r <= best_nxt; cur_r <= cur_nxt; bent_r <= bent_nxt;
    st_r <= st_nxt; odata_r <= odata_nxt;
  end

  assign in_tready  = (state_r == bmhq_pkg::S_IDLE);
  assign out_tvalid = (state_r == bmhq_pkg::S_OUT);
  assign out_tdata  = odata_r;

  // sequencer
  always_comb begin
    bmhq_pkg::cmd_t cmd;
    cmd = bmhq_pkg::cmd_t'(in_tdata[1:0]);
    state_nxt = state_r; cnt_nxt = cnt_r; pos_nxt = pos_r; best_nxt = best_r;
    cur_nxt = cur_r; bent_nxt = bent_r; st_nxt = st_r; odata_nxt = odata_r;
    rd_addr = '0; wr_addr = pos_r[AW-1:0]; wr_en = 1'b0; wr_data = cur_r;
    unique case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          st_nxt = bmhq_pkg::ST_DONE;
          state_nxt = bmhq_pkg::S_TOP_RD;
          unique case (cmd)
            bmhq_pkg::CMD_ENQ: begin
              if (cnt_r >= CapC) st_nxt = bmhq_pkg::ST_FULL;
              else begin
                cur_nxt = in_tdata[35:2];
                pos_nxt = (AW+1)'(cnt_r);
                cnt_nxt = cnt_r + 1'b1;
                wr_en = 1'b1; wr_addr = cnt_r[AW-1:0]; wr_data = in_tdata[35:2];
                state_nxt = bmhq_pkg::S_UP_RD;
              end
            end
            bmhq_pkg::CMD_DEQ: begin
              if (cnt_r == '0) st_nxt = bmhq_pkg::ST_EMPTY;
              else begin
                cnt_nxt = cnt_r - 1'b1;
                pos_nxt = '0;
                state_nxt = (cnt_r > CW'(1)) ? bmhq_pkg::S_DN_RD0 : bmhq_pkg::S_TOP_RD;
              end
            end
            bmhq_pkg::CMD_PEEK: if (cnt_r == '0) st_nxt = bmhq_pkg::ST_EMPTY;
            default: ;
          endcase
        end
      end
      // read parent of the moving entry, or settle it at the root
      bmhq_pkg::S_UP_RD: begin
        rd_addr = par[AW-1:0];
        if (pos_r == '0) begin
          wr_en = 1'b1; wr_addr = '0; wr_data = cur_r;
          state_nxt = bmhq_pkg::S_TOP_RD;
        end else begin
          state_nxt = bmhq_pkg::S_UP_CMP;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (bmhq_pkg::goes_before(cur_r, rd_data_r)) begin
          wr_en = 1'b1; wr_addr = pos_r[AW-1:0]; wr_data = rd_data_r;
          pos_nxt = par;
          state_nxt = bmhq_pkg::S_UP_RD;
        end else begin
          wr_en = 1'b1; wr_addr = pos_r[AW-1:0]; wr_data = cur_r;
          state_nxt = bmhq_pkg::S_TOP_RD;
        end
      end
      // fetch last entry, it becomes the sifting entry at the root
      bmhq_pkg::S_DN_RD0: begin
        rd_addr = cnt_r[AW-1:0];
        state_nxt = bmhq_pkg::S_DN_RD1;
      end
      bmhq_pkg::S_DN_RD1: begin
        if (pos_r == '0) cur_nxt = rd_data_r;
        rd_addr = lch[AW-1:0];
        state_nxt = bmhq_pkg::S_DN_RD2;
      end
      bmhq_pkg::S_DN_RD2: begin
        rd_addr = rch[AW-1:0];
        best_nxt = pos_r; bent_nxt = cur_r;
        if (lch < (AW+1)'(cnt_r) && bmhq_pkg::goes_before(rd_data_r, cur_r)) begin
          best_nxt = lch; bent_nxt = rd_data_r;
        end
        state_nxt = bmhq_pkg::S_DN_CMP;
      end
      bmhq_pkg::S_DN_CMP: begin
        logic [AW:0] b;
        bmhq_pkg::entry_t be;
        b = best_r; be = bent_r;
        if (rch < (AW+1)'(cnt_r) && bmhq_pkg::goes_before(rd_data_r, bent_r)) begin
          b = rch; be = rd_data_r;
        end
        wr_en = 1'b1; wr_addr = pos_r[AW-1:0];
        if (b == pos_r) begin
          wr_data = cur_r;
          state_nxt = bmhq_pkg::S_TOP_RD;
        end else begin
          wr_data = be;
          pos_nxt = b;
          state_nxt = bmhq_pkg::S_DN_RD1;
        end
      end
      bmhq_pkg::S_TOP_RD: begin
        rd_addr = '0;
        state_nxt = bmhq_pkg::S_TOP_WT;
      end
      bmhq_pkg::S_TOP_WT: begin
        odata_nxt = '0;
        odata_nxt[1:0] = st_r;
        if (cnt_r != '0) odata_nxt[35:2] = rd_data_r;
        odata_nxt[42:36] = 7'(cnt_r);
        odata_nxt[43] = (cnt_r == '0);
        odata_nxt[44] = (cnt_r == CapC);
        state_nxt = bmhq_pkg::S_OUT;
      end
      bmhq_pkg::S_OUT: if (out_tready) state_nxt = bmhq_pkg::S_IDLE;
      default: state_nxt = bmhq_pkg::S_IDLE;
    endcase
  end
endmodule
